[rtl/core/assert_macros.svh]
// Assertion shorthands shared by the core modules.
// Each expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HRPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRPA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hrpa_pkg.sv]
package hrpa_pkg;

    // Page geometry. The page buffer holds two banks of BANK_SPAN bytes,
    // stored as rows of eight bytes so that a take reads one row per cycle while the output is not stalled.
    localparam int PAGE_SIZE  = 128;
    localparam int BANK_SPAN  = 128;
    localparam int ROW_BYTES  = 8;
    localparam int BANK_ROWS  = BANK_SPAN / ROW_BYTES;
    localparam int ROW_AW     = $clog2(BANK_ROWS);
    localparam int RAM_AW     = ROW_AW + 1;
    localparam int RAM_DEPTH  = 2 * BANK_ROWS;
    localparam int ROW_W      = 8 * ROW_BYTES;
    localparam int PAGE_WORDS = (PAGE_SIZE + ROW_BYTES - 1) / ROW_BYTES;

    localparam logic [ROW_AW-1:0] LAST_ROW  = ROW_AW'(PAGE_WORDS - 1);
    localparam logic [7:0]        PAGE_FULL = 8'(PAGE_SIZE);

    localparam logic [15:0] ADDR_STEP = 16'h0040;
    localparam logic [7:0]  PAD_BYTE  = 8'hFF;
    localparam logic [7:0]  CH_COLON  = 8'h3A;

    // Character positions within a record line.
    localparam logic [9:0] POS_IDLE    = 10'd0;
    localparam logic [9:0] POS_LEN_HI  = 10'd1;
    localparam logic [9:0] POS_LEN_LO  = 10'd2;
    localparam logic [9:0] POS_KIND_HI = 10'd7;
    localparam logic [9:0] POS_KIND_LO = 10'd8;
    localparam logic [9:0] POS_DATA    = 10'd9;
    localparam logic [9:0] POS_MAX     = 10'd1023;

    localparam logic [7:0] KIND_DATA = 8'h00;
    localparam logic [7:0] KIND_EOF  = 8'h01;

    localparam logic REQ_CHAR   = 1'b0;
    localparam logic REQ_TAKE   = 1'b1;
    localparam logic RES_STATUS = 1'b0;
    localparam logic RES_WORD   = 1'b1;

    // Result tdata: page_ready, load_address, page_word, zero fill to bytes.
    localparam int OUT_FIELD_W = 1 + 16 + ROW_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [2:0]        lane;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        logic        ready;
        logic [15:0] word_address;
        logic        fill_bank;
        logic        padded;
        logic [7:0]  pad_from;
    } t_page_stat;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

[rtl/core/hrpa_page_ram.sv]
module hrpa_page_ram
    import hrpa_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [RAM_AW-1:0] i_rd_addr,
    output logic [ROW_W-1:0]  o_rd_data
);

    logic [ROW_W-1:0] r_mem [0:RAM_DEPTH-1];
    logic [ROW_W-1:0] r_rd_data;

    // Byte-lane write; a row is read whole and held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr][{i_wr.lane, 3'b000} +: 8] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/hrpa_record_parser.sv]
`include "assert_macros.svh"

module hrpa_record_parser
    import hrpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_char_en,
    input  logic [7:0] i_char,
    input  logic       i_take_en,
    output t_page_stat o_stat,
    output t_page_stat o_next_stat,
    output t_ram_wr    o_wr
);

    logic [9:0]  r_pos,       n_pos;
    logic [7:0]  r_len,       n_len;
    logic [7:0]  r_kind,      n_kind;
    logic [3:0]  r_nibble,    n_nibble;
    logic        r_fill_bank, n_fill_bank;
    logic [7:0]  r_fill_index, n_fill_index;
    logic [7:0]  r_pad_from,  n_pad_from;
    logic        r_padded,    n_padded;
    logic [15:0] r_word_address, n_word_address;
    logic        r_first,     n_first;
    logic        r_ready,     n_ready;

    logic [3:0]  digit;
    logic [7:0]  byte_val;
    logic [9:0]  offset;
    logic [7:0]  index_inc;

    assign digit     = hex_value(i_char);
    assign byte_val  = {r_nibble, digit};
    assign offset    = r_pos - POS_DATA;
    assign index_inc = r_fill_index + 8'd1;

    always_comb begin
        n_pos          = r_pos;
        n_len          = r_len;
        n_kind         = r_kind;
        n_nibble       = r_nibble;
        n_fill_bank    = r_fill_bank;
        n_fill_index   = r_fill_index;
        n_pad_from     = r_pad_from;
        n_padded       = r_padded;
        n_word_address = r_word_address;
        n_first        = r_first;
        n_ready        = r_ready;

        o_wr.we   = 1'b0;
        o_wr.addr = {r_fill_bank, r_fill_index[ROW_AW+2:3]};
        o_wr.lane = r_fill_index[2:0];
        o_wr.data = byte_val;

        if (i_take_en) begin
            n_ready = 1'b0;
        end

        if (i_char_en) begin
            if (i_char == CH_COLON) begin
                n_pos    = POS_LEN_HI;
                n_len    = 8'h00;
                n_kind   = 8'h00;
                n_nibble = 4'h0;
            end else if (r_pos != POS_IDLE) begin
                if (r_pos == POS_LEN_HI || r_pos == POS_KIND_HI) begin
                    n_nibble = digit;
                end else if (r_pos == POS_LEN_LO) begin
                    n_len = byte_val;
                end else if (r_pos == POS_KIND_LO) begin
                    n_kind = byte_val;
                    if (byte_val == KIND_EOF) begin
                        // End record: the part-filled page goes out padded.
                        n_word_address = r_word_address + ADDR_STEP;
                        n_padded       = 1'b1;
                        n_pad_from     = r_fill_index;
                        n_ready        = 1'b1;
                        n_fill_bank    = ~r_fill_bank;
                        n_fill_index   = 8'h00;
                    end
                end else if (r_pos >= POS_DATA) begin
                    if (!offset[0]) begin
                        n_nibble = digit;
                    end else if ({1'b0, r_len} > offset[9:1] && r_kind == KIND_DATA) begin
                        o_wr.we = 1'b1;
                        if (index_inc == PAGE_FULL) begin
                            // The first full page keeps the start address.
                            if (!r_first) begin
                                n_word_address = r_word_address + ADDR_STEP;
                            end
                            n_first      = 1'b0;
                            n_padded     = 1'b0;
                            n_pad_from   = index_inc;
                            n_ready      = 1'b1;
                            n_fill_bank  = ~r_fill_bank;
                            n_fill_index = 8'h00;
                        end else begin
                            n_fill_index = index_inc;
                        end
                    end
                end
                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= POS_IDLE;
            r_len          <= 8'h00;
            r_kind         <= 8'h00;
            r_nibble       <= 4'h0;
            r_fill_bank    <= 1'b0;
            r_fill_index   <= 8'h00;
            r_pad_from     <= 8'h00;
            r_padded       <= 1'b0;
            r_word_address <= 16'h0000;
            r_first        <= 1'b1;
            r_ready        <= 1'b0;
        end else begin
            r_pos          <= n_pos;
            r_len          <= n_len;
            r_kind         <= n_kind;
            r_nibble       <= n_nibble;
            r_fill_bank    <= n_fill_bank;
            r_fill_index   <= n_fill_index;
            r_pad_from     <= n_pad_from;
            r_padded       <= n_padded;
            r_word_address <= n_word_address;
            r_first        <= n_first;
            r_ready        <= n_ready;
        end
    end

    assign o_stat.ready        = r_ready;
    assign o_stat.word_address = r_word_address;
    assign o_stat.fill_bank    = r_fill_bank;
    assign o_stat.padded       = r_padded;
    assign o_stat.pad_from     = r_pad_from;

    assign o_next_stat.ready        = n_ready;
    assign o_next_stat.word_address = n_word_address;
    assign o_next_stat.fill_bank    = n_fill_bank;
    assign o_next_stat.padded       = n_padded;
    assign o_next_stat.pad_from     = n_pad_from;

    `HRPA_ASSERT_IMP(a_fill_in_page, 1'b1, r_fill_index < PAGE_FULL, "fill index ran past the page")
    `HRPA_ASSERT_IMP(a_ready_from_char, $rose(r_ready), $past(i_char_en), "page ready without a character")

endmodule

[rtl/core/hex_record_page_assembler_core.sv]
// Channel   Direction  tdata                                       tuser        tlast
// s_        in         char_in[7:0]                                req_type     -
// m_        out        page_ready, load_address, page_word, zeros  result_kind  word_last
//
// A character request, or a take with no page ready, gives one status result.
// A take request of a ready page gives PAGE_WORDS results, one per cycle while the
// output is not stalled, paced by the single read port of the page buffer; the
// block takes no new request until the last word is sent.
// Reset is synchronous and clears the control state at once; the page buffer is not cleared.
// While a result waits in the output register and is not taken, no new request is accepted.
`include "assert_macros.svh"

module hex_record_page_assembler_core
    import hrpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // char_in[7:0]
    input  logic                  i_s_tuser,   // req_type
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] page_ready, [16:1] load_address, [80:17] page_word, above: zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser,   // result_kind
    output logic                  o_m_tlast    // word_last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TAKE = 1'b1;

    logic                  r_state, n_state;
    logic [ROW_AW-1:0]     r_word,  n_word;
    logic                  r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data,  n_m_data;
    logic                  r_m_user,  n_m_user;
    logic                  r_m_last,  n_m_last;

    logic       out_free;
    logic       in_acc;
    logic       char_en;
    logic       take_req;
    logic       take_en;
    t_page_stat stat;
    t_page_stat next_stat;
    t_ram_wr    wr;

    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [ROW_W-1:0]  rd_data;
    logic [ROW_W-1:0]  page_word;

    assign out_free   = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign char_en    = in_acc && (i_s_tuser == REQ_CHAR);
    assign take_req   = in_acc && (i_s_tuser == REQ_TAKE);
    assign take_en    = take_req && stat.ready;

    hrpa_record_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_en   (char_en),
        .i_char      (i_s_tdata),
        .i_take_en   (take_en),
        .o_stat      (stat),
        .o_next_stat (next_stat),
        .o_wr        (wr)
    );

    // The ready page sits in the bank not being filled. Row 0 is fetched as
    // the take is accepted; each word sent but the last fetches the next row.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {~stat.fill_bank, {ROW_AW{1'b0}}};
        if (take_en) begin
            rd_en = 1'b1;
        end else if (r_state == ST_TAKE && out_free && r_word != LAST_ROW) begin
            rd_en   = 1'b1;
            rd_addr = {~stat.fill_bank, r_word + {{(ROW_AW-1){1'b0}}, 1'b1}};
        end
    end

    hrpa_page_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Bytes from the end-record point on read as pad; bytes past the page as zero.
    always_comb begin
        logic [7:0] idx;
        page_word = '0;
        for (int i = 0; i < ROW_BYTES; i++) begin
            idx = {1'b0, r_word, 3'(i)};
            if (idx >= PAGE_FULL) begin
                page_word[8*i +: 8] = 8'h00;
            end else if (stat.padded && idx >= stat.pad_from) begin
                page_word[8*i +: 8] = PAD_BYTE;
            end else begin
                page_word[8*i +: 8] = rd_data[8*i +: 8];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_word    = r_word;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        n_m_last  = r_m_last;

        if (char_en || (take_req && !stat.ready)) begin
            n_m_valid = 1'b1;
            n_m_user  = RES_STATUS;
            n_m_data  = {{OUT_PAD_W{1'b0}}, {ROW_W{1'b0}},
                         next_stat.word_address, next_stat.ready};
            n_m_last  = 1'b0;
        end

        if (take_en) begin
            n_state = ST_TAKE;
            n_word  = '0;
        end

        if (r_state == ST_TAKE && out_free) begin
            n_m_valid = 1'b1;
            n_m_user  = RES_WORD;
            n_m_data  = {{OUT_PAD_W{1'b0}}, page_word, stat.word_address, stat.ready};
            n_m_last  = (r_word == LAST_ROW);
            if (r_word == LAST_ROW) begin
                n_state = ST_IDLE;
            end else begin
                n_word = r_word + {{(ROW_AW-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_word    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_word    <= n_word;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

    `HRPA_ASSERT_IMP(a_bank_held, (r_state == ST_TAKE) && $past(r_state == ST_TAKE), $stable(stat.fill_bank), "page bank moved during a take")
    `HRPA_ASSERT_IMP(a_word_not_ready, o_m_tvalid && (o_m_tuser == RES_WORD), !o_m_tdata[0], "page word shows a ready page")

endmodule
